[hdl/nalss_pkg.sv]
// Package: constants and types shared by the NAL unit splitter files.
`default_nettype none
package nalss_pkg;
  localparam int STORE_DEPTH = 8192;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W = 14;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(4096);
  localparam logic [LEN_W-1:0] MIN_LIMIT = LEN_W'(8);
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE = 8'h01;
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       frame_dropped;
  } out_word_t;

  // store write request
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } st_wr_t;
endpackage
`default_nettype wire

[hdl/nalss_if.sv]
// Interfaces: valid/ready channels for input and result words.
`default_nettype none
interface nalss_in_if (input wire logic clk);
  import nalss_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nalss_out_if (input wire logic clk);
  import nalss_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/nal_unit_start_code_splitter.sv]
// Top level: H.264 Annex B stream splitter into NAL units.
// Usage:
//  - in: words with opcode (push a stream byte / pull an output byte) and data_byte.
//  - out: one result word per input word (accepted, out_valid, out_byte, out_last,
//    frame_dropped).
//  - cfg: cfg_we/cfg_wdata write max_frame_len (clamped to 8..STORE_DEPTH-1).
// Timing: a word is processed by a small sequencer around the byte store memory.
//  A plain push or a pull with nothing queued goes from the accept straight to the
//  result register. A pull that returns a byte passes through read issue and the
//  registered store read before the result. A push that drops an unstarted segment
//  or an oversized one rewrites 3-4 bytes of the store, one byte at a time through
//  the single store write port, before the result.
// One word is in work at a time; the result sits in an output register, and the
//  next word is taken in the cycle after the result is taken.
// Reset (rst_n low, synchronous) empties the store and queue and sets the limit to
//  4096; no clearing pass is needed since no unwritten entry is ever read.
// Receiver stall: the result register holds and no new word is taken.
`default_nettype none
module nal_unit_start_code_splitter (
  input  wire logic clk,
  input  wire logic rst_n,
  nalss_in_if.sink  in_ch,
  nalss_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [nalss_pkg::LEN_W-1:0] cfg_wdata
);
  import nalss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_FIX   = 5'b00100,
    S_OUT   = 5'b01000,
    S_PULLD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [LEN_W-1:0] max_len_r;
  logic [PTR_W-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [LEN_W-1:0] seg_len_r, seg_len_nxt, left_r, left_nxt;
  logic             started_r, started_nxt;
  logic [23:0]      hist_r, hist_nxt;
  out_word_t        res_r, res_nxt;
  // fix-up writes: up to 4 bytes at fix_base
  logic [PTR_W-1:0] fix_base_r, fix_base_nxt;
  logic [2:0]       fix_n_r, fix_n_nxt, fix_i_r, fix_i_nxt;
  logic [23:0]      fix_bytes_r, fix_bytes_nxt; // oversize keep bytes
  logic             fix_sc_r, fix_sc_nxt;        // writing start code pattern

  st_wr_t           st_wr;
  logic [PTR_W-1:0] st_raddr;
  logic [7:0]       st_rdata;
  logic             q_push, q_pop;
  logic [LEN_W-1:0] q_push_len, q_head;
  logic [QCNT_W-1:0] q_count;

  nalss_store u_store (.clk(clk), .wr(st_wr), .rd_addr(st_raddr), .rd_data(st_rdata));
  nalss_queue u_queue (.clk(clk), .rst_n(rst_n), .push(q_push), .push_len(q_push_len),
                       .pop(q_pop), .head_len(q_head), .count(q_count));

  // push decode
  logic [7:0]       d, b2, b1, b0;
  logic [LEN_W:0]   len;
  logic             sc3, sc4, use4, use3, full;
  logic [LEN_W-1:0] limit;
  logic [PTR_W-1:0] occ, wp_inc, base;

  always_comb begin
    d = in_ch.data.data_byte;
    b2 = hist_r[23:16];
    b1 = hist_r[15:8];
    b0 = hist_r[7:0];
    len = {1'b0, seg_len_r} + (LEN_W+1)'(1);
    sc3 = (b1 == SC_ZERO) && (b0 == SC_ZERO) && (d == SC_ONE);
    sc4 = sc3 && (b2 == SC_ZERO);
    use4 = sc4 && (len >= (LEN_W+1)'(6));
    use3 = !use4 && sc3 && (len >= (LEN_W+1)'(5));
    occ = wp_r - rp_r;
    full = (32'(occ) >= STORE_DEPTH - 1);
    wp_inc = wp_r + PTR_W'(1);
    base = wp_inc - PTR_W'(len);
    if (max_len_r < MIN_LIMIT) limit = MIN_LIMIT;
    else if (32'(max_len_r) > STORE_DEPTH - 1) limit = LEN_W'(STORE_DEPTH - 1);
    else limit = max_len_r;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = res_r;

  always_comb begin
    state_nxt = state_r;
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    seg_len_nxt = seg_len_r;
    left_nxt = left_r;
    started_nxt = started_r;
    hist_nxt = hist_r;
    res_nxt = res_r;
    fix_base_nxt = fix_base_r;
    fix_n_nxt = fix_n_r;
    fix_i_nxt = fix_i_r;
    fix_bytes_nxt = fix_bytes_r;
    fix_sc_nxt = fix_sc_r;
    st_wr = '{we: 1'b0, addr: wp_r, data: d};
    st_raddr = rp_r;
    q_push = 1'b0;
    q_pop = 1'b0;
    q_push_len = LEN_W'(len - (LEN_W+1)'(use4 ? 4 : 3));
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '0;
          state_nxt = S_OUT;
          if (in_ch.data.opcode == OP_PUSH) begin
            if (!full && !((use4 || use3) && started_r &&
                           32'(q_count) >= QUEUE_DEPTH)) begin
              res_nxt.accepted = 1'b1;
              st_wr.we = 1'b1;
              wp_nxt = wp_inc;
              hist_nxt = {hist_r[15:0], d};
              if (use4 || use3) begin
                seg_len_nxt = use4 ? LEN_W'(4) : LEN_W'(3);
                started_nxt = 1'b1;
                if (started_r) begin
                  q_push = 1'b1;
                end else begin
                  res_nxt.frame_dropped = 1'b1;
                  fix_base_nxt = base;
                  fix_n_nxt = use4 ? 3'd4 : 3'd3;
                  fix_i_nxt = '0;
                  fix_sc_nxt = 1'b1;
                  wp_nxt = base + PTR_W'(use4 ? 4 : 3);
                  state_nxt = S_FIX;
                end
              end else begin
                seg_len_nxt = LEN_W'(len);
                if (!started_r && ((sc4 && len == (LEN_W+1)'(4)) ||
                                   (sc3 && len == (LEN_W+1)'(3))))
                  started_nxt = 1'b1;
                if (len >= {1'b0, limit}) begin
                  res_nxt.frame_dropped = 1'b1;
                  seg_len_nxt = LEN_W'(3);
                  started_nxt = 1'b0;
                  fix_base_nxt = base;
                  fix_n_nxt = 3'd3;
                  fix_i_nxt = '0;
                  fix_sc_nxt = 1'b0;
                  fix_bytes_nxt = {b1, b0, d};
                  wp_nxt = base + PTR_W'(3);
                  state_nxt = S_FIX;
                end
              end
            end
          end else begin
            // pull: load next unit length if needed, then read store
            if (left_r == '0) begin
              if (q_count != '0) begin
                q_pop = 1'b1;
                left_nxt = q_head;
                if (q_head != '0) state_nxt = S_READ;
              end
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        st_raddr = rp_r;
        state_nxt = S_PULLD;
      end
      S_PULLD: begin
        res_nxt.out_valid = 1'b1;
        res_nxt.out_byte = st_rdata;
        res_nxt.out_last = (left_r == LEN_W'(1));
        left_nxt = left_r - LEN_W'(1);
        rp_nxt = rp_r + PTR_W'(1);
        state_nxt = S_OUT;
      end
      S_FIX: begin
        st_wr.we = 1'b1;
        st_wr.addr = fix_base_r + PTR_W'(fix_i_r);
        if (fix_sc_r)
          st_wr.data = (fix_i_r + 3'd1 == fix_n_r) ? SC_ONE : SC_ZERO;
        else
          st_wr.data = fix_bytes_r[23:16];
        fix_bytes_nxt = {fix_bytes_r[15:0], 8'h00};
        fix_i_nxt = fix_i_r + 3'd1;
        if (fix_i_r + 3'd1 == fix_n_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    fix_base_r <= fix_base_nxt;
    fix_n_r <= fix_n_nxt;
    fix_i_r <= fix_i_nxt;
    fix_bytes_r <= fix_bytes_nxt;
    fix_sc_r <= fix_sc_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_len_r <= MAX_LEN_RESET;
      wp_r <= '0;
      rp_r <= '0;
      seg_len_r <= '0;
      left_r <= '0;
      started_r <= 1'b0;
      hist_r <= 24'hFFFFFF;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) max_len_r <= cfg_wdata;
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      seg_len_r <= seg_len_nxt;
      left_r <= left_nxt;
      started_r <= started_nxt;
      hist_r <= hist_nxt;
    end
  end

  a_pull_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> left_r == '0) else $error("pop while unit open");
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PULLD && left_r == LEN_W'(1)) |=> left_r == '0)
    else $error("last byte mismatch");
  a_fix_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX |-> st_wr.we) else $error("fix without write");
endmodule
`default_nettype wire

[hdl/nalss_store.sv]
// Byte store: single write port, registered read port.
`default_nettype none
module nalss_store (
  input  wire logic                      clk,
  input  wire nalss_pkg::st_wr_t         wr,
  input  wire logic [nalss_pkg::PTR_W-1:0] rd_addr,
  output logic [7:0]                     rd_data
);
  import nalss_pkg::*;
  logic [7:0] mem [STORE_DEPTH];
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[hdl/nalss_queue.sv]
// Unit length queue: circular memory of completed unit lengths.
`default_nettype none
module nalss_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [nalss_pkg::LEN_W-1:0]  push_len,
  input  wire logic                         pop,
  output logic [nalss_pkg::LEN_W-1:0]       head_len,
  output logic [nalss_pkg::QCNT_W-1:0]      count
);
  import nalss_pkg::*;
  logic [LEN_W-1:0]  mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QIDX_W-1:0] inc(input logic [QIDX_W-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) return '0;
    return p + QIDX_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_len;
    end
  end
  assign head_len = mem[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (32'(cnt_r) < QUEUE_DEPTH)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + QCNT_W'(1)) else $error("count");
endmodule
`default_nettype wire

[verif/nalss_checker.sv]
// Checker: predicts NAL unit splitter results and compares them with the result channel.
`default_nettype none
module nalss_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  nalss_in_if       in_ch,
  nalss_out_if      out_ch,
  input  wire logic cfg_we,
  input  wire logic [nalss_pkg::LEN_W-1:0] cfg_wdata,
  output int        fail_count,
  output int        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import nalss_pkg::*;

  logic [7:0]       unit_bytes [STORE_DEPTH];
  int               wr_ptr, rd_ptr, seg_len, bytes_left;
  logic             seg_open;
  logic [23:0]      last3;
  int               unit_lens [$];
  logic [LEN_W-1:0] frame_limit;
  out_word_t        expected_words [$];

  function automatic int wrap(int p);
    return ((p % STORE_DEPTH) + STORE_DEPTH) % STORE_DEPTH;
  endfunction

  function automatic int clamped_limit();
    int m;
    m = frame_limit;
    if (m < MIN_LIMIT) m = MIN_LIMIT;
    if (m > STORE_DEPTH - 1) m = STORE_DEPTH - 1;
    return m;
  endfunction

  function automatic out_word_t split_byte(logic [7:0] d);
    out_word_t r;
    int occ, len, p3, p4, pos, k, base;
    logic [7:0] b2, b1, b0;
    logic sc3, sc4;
    r = '0;
    occ = wrap(wr_ptr - rd_ptr);
    b2 = last3[23:16];
    b1 = last3[15:8];
    b0 = last3[7:0];
    len = seg_len + 1;
    sc3 = (b1 == SC_ZERO) && (b0 == SC_ZERO) && (d == SC_ONE);
    sc4 = sc3 && (b2 == SC_ZERO);
    p4 = len - 4;
    p3 = len - 3;
    k = 0;
    pos = -1;
    if (occ >= STORE_DEPTH - 1) return r;
    if (sc4 && p4 >= 2) begin
      k = 4; pos = p4;
    end else if (sc3 && p3 >= 2) begin
      k = 3; pos = p3;
    end
    if (k != 0 && seg_open && unit_lens.size() >= QUEUE_DEPTH) return r;
    r.accepted = 1'b1;
    unit_bytes[wr_ptr] = d;
    wr_ptr = wrap(wr_ptr + 1);
    last3 = {last3[15:0], d};
    base = wrap(wr_ptr - len);
    if (k != 0) begin
      if (seg_open) begin
        unit_lens.push_back(pos);
      end else begin
        // unstarted segment: keep only the start code
        for (int i = 0; i < k; i++)
          unit_bytes[wrap(base + i)] = (i + 1 == k) ? SC_ONE : SC_ZERO;
        wr_ptr = wrap(base + k);
        r.frame_dropped = 1'b1;
      end
      seg_len = k;
      seg_open = 1'b1;
      return r;
    end
    seg_len = len;
    if (!seg_open && ((sc4 && p4 == 0) || (sc3 && p3 == 0))) seg_open = 1'b1;
    if (seg_len >= clamped_limit()) begin
      // oversized: keep the tail so a split start code is still seen
      unit_bytes[base] = b1;
      unit_bytes[wrap(base + 1)] = b0;
      unit_bytes[wrap(base + 2)] = d;
      wr_ptr = wrap(base + 3);
      seg_len = 3;
      seg_open = 1'b0;
      r.frame_dropped = 1'b1;
    end
    return r;
  endfunction

  function automatic out_word_t next_unit_byte();
    out_word_t r;
    r = '0;
    if (bytes_left == 0) begin
      if (unit_lens.size() == 0) return r;
      bytes_left = unit_lens.pop_front();
      if (bytes_left == 0) return r;
    end
    r.out_valid = 1'b1;
    r.out_byte = unit_bytes[rd_ptr];
    rd_ptr = wrap(rd_ptr + 1);
    bytes_left--;
    r.out_last = (bytes_left == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign words_pending = expected_words.size();

  always @(posedge clk) begin
    out_word_t w, e;
    if (!rst_n) begin
      wr_ptr = 0; rd_ptr = 0; seg_len = 0; bytes_left = 0;
      seg_open = 1'b0; last3 = 24'hFFFFFF;
      unit_lens.delete();
      expected_words.delete();
      frame_limit = MAX_LEN_RESET;
    end else begin
      if (cfg_we) frame_limit = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        w = out_ch.data;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", w, 0);
        end else begin
          e = expected_words.pop_front();
          if (w.accepted != e.accepted) report_mismatch("accepted", w.accepted, e.accepted);
          if (w.out_valid != e.out_valid) report_mismatch("out_valid", w.out_valid, e.out_valid);
          if (w.out_byte != e.out_byte) report_mismatch("out_byte", w.out_byte, e.out_byte);
          if (w.out_last != e.out_last) report_mismatch("out_last", w.out_last, e.out_last);
          if (w.frame_dropped != e.frame_dropped)
            report_mismatch("frame_dropped", w.frame_dropped, e.frame_dropped);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_words.push_back(in_ch.data.opcode == OP_PULL ? next_unit_byte()
                                                                : split_byte(in_ch.data.data_byte));
    end
  end
endmodule
`default_nettype wire

[verif/tb_nal_unit_start_code_splitter.sv]
// Testbench top: drives pushes, pulls and limit writes into the NAL unit splitter.
`default_nettype none
module tb_nal_unit_start_code_splitter;
  timeunit 1ns;
  timeprecision 1ps;
  import nalss_pkg::*;

  localparam int STALL_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  int               fail_count, words_pending;
  bit               no_gaps = 1'b0;   // quiet stretch: neither side idles
  bit               hold_rx = 1'b0;   // request a long receiver stall
  int               idle_cycles = 0;

  nalss_in_if  in_ch (clk);
  nalss_out_if out_ch (clk);

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  nal_unit_start_code_splitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nalss_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // Receiver: ready drops in about 22% of cycles; a hold request stalls it for
  // a long stretch so the splitter backs up and refuses new words.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: cycles in a row with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("** nal_unit_start_code_splitter: FAILED **");
      $finish;
    end
  end

  // Offer one word; valid stays high afterwards unless the next call idles.
  task automatic send_word(logic op, logic [7:0] b);
    in_word_t w;
    w.opcode = op;
    w.data_byte = b;
    if (!no_gaps && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic push(logic [7:0] b);
    send_word(OP_PUSH, b);
  endtask

  task automatic pull(int n);
    repeat (n) send_word(OP_PULL, 8'($urandom));
  endtask

  // Sender pause: drop valid and wait for every result to come back.
  task automatic drain_results();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);  // covers the slowest rewrite of the store
  endtask

  task automatic set_frame_limit(logic [LEN_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_start_code(bit four);
    if (four) push(SC_ZERO);
    push(SC_ZERO);
    push(SC_ZERO);
    push(SC_ONE);
  endtask

  // One unit: start code then a body with plenty of zeros, pulls mixed in.
  task automatic random_unit(int body_len, int pull_pct);
    logic [7:0] b;
    push_start_code($urandom_range(1));
    for (int i = 0; i < body_len; i++) begin
      case ($urandom_range(9))
        0, 1:    b = SC_ZERO;
        2:       b = SC_ONE;
        default: b = 8'($urandom);
      endcase
      push(b);
      if ($urandom_range(99) < pull_pct) pull($urandom_range(3, 1));
    end
  endtask

  initial begin
    logic [LEN_W-1:0] limits [6];
    limits = '{LEN_W'(20), LEN_W'(3), LEN_W'(8), LEN_W'(16383), LEN_W'(8191), LEN_W'(4096)};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pull with nothing queued, a started unit, a four-byte closing code.
    pull(1);
    push_start_code(0);
    push(8'hFF);
    push(8'h80);
    push_start_code(1);
    pull(7);
    // More units closed by three- and four-byte start codes, then pulls.
    push(8'h55);
    push(8'h66);
    push_start_code(0);
    push(8'h7F);
    push_start_code(0);
    push_start_code(1);
    pull(12);

    // Queue full: more units than the queue holds, no pulls; then drain.
    no_gaps = 1'b1;
    for (int u = 0; u < QUEUE_DEPTH + 2; u++) begin
      push_start_code(0);
      push(8'hA5);
    end
    no_gaps = 1'b0;
    pull(80);

    // Random phases across limit settings, extremes included.
    foreach (limits[i]) begin
      set_frame_limit(limits[i]);
      for (int u = 0; u < 7; u++) begin
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(12, 1)) push(8'($urandom));  // noise, no start code
        random_unit(($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(10),
                    45);
      end
      if (i == 1) begin
        no_gaps = 1'b1;  // long stretch without idling
        for (int u = 0; u < 10; u++) random_unit($urandom_range(8), 50);
        no_gaps = 1'b0;
      end
      if (i == 2) begin
        hold_rx = 1'b1;  // receiver stalls while we keep offering words
        for (int u = 0; u < 6; u++) random_unit($urandom_range(6), 30);
      end
      pull(40);
    end

    drain_results();
    if (fail_count == 0)
      $display("** nal_unit_start_code_splitter: PASSED **");
    else
      $display("** nal_unit_start_code_splitter: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
